[design/bvg_pkg.sv]
// ----------------------------------------------------------------------------
// Battery voltage gauge package
// Field widths, register indexes, configuration struct and the fixed
// charge curve (breakpoints, slopes and reciprocals per segment).
// ----------------------------------------------------------------------------
package bvg_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int RATIO_W     = 4;
   localparam int MV_LIMIT_W  = 14;
   localparam int QMV_W       = 17;
   localparam int MV_W        = 15;
   localparam int PCT_W       = 7;
   localparam int SEG_W       = 3;
   localparam int DIFF_W      = 10;
   localparam int DP_W        = 5;
   localparam int DV_W        = 11;
   localparam int SDIFF_W     = DIFF_W + DP_W;
   localparam int NUM_W       = 16;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 27;
   localparam int QUO_W       = NUM_W + RECIP_W;

   localparam logic [QMV_W-1:0] QMV_MAX  = 17'h1FFFF;
   localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   localparam int RECIP_1600 = ((2 ** RECIP_SHIFT) + 1599) / 1600;
   localparam int RECIP_800  = ((2 ** RECIP_SHIFT) + 799) / 800;
   localparam int RECIP_1200 = ((2 ** RECIP_SHIFT) + 1199) / 1200;
   localparam int RECIP_2000 = ((2 ** RECIP_SHIFT) + 1999) / 2000;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type REG_DIVIDER_RATIO  = 2'd0;
   localparam csr_index_type REG_PLAUSIBLE_LOW  = 2'd1;
   localparam csr_index_type REG_PLAUSIBLE_HIGH = 2'd2;

   typedef logic [SAMPLE_W-1:0]   sample_type;
   typedef logic [MV_LIMIT_W-1:0] csr_data_type;
   typedef logic [QMV_W-1:0]      qmv_type;
   typedef logic [MV_W-1:0]       mv_type;
   typedef logic [PCT_W-1:0]      pct_type;
   typedef logic [SEG_W-1:0]      seg_type;

   typedef struct packed {
      logic [RATIO_W-1:0]    divider_ratio;
      logic [MV_LIMIT_W-1:0] plausible_low_mv;
      logic [MV_LIMIT_W-1:0] plausible_high_mv;
   } cfg_type;

   localparam seg_type SEG_EMPTY = 3'd0;
   localparam seg_type SEG_FULL  = 3'd6;

   function automatic qmv_type bp_qmv(input seg_type i);
      case (i)
         3'd0:    return QMV_W'(13600);
         3'd1:    return QMV_W'(14400);
         3'd2:    return QMV_W'(14800);
         3'd3:    return QMV_W'(15200);
         3'd4:    return QMV_W'(15800);
         3'd5:    return QMV_W'(16800);
         default: return QMV_MAX;
      endcase
   endfunction

   function automatic logic [DP_W-1:0] seg_dp(input seg_type i);
      case (i)
         3'd1:    return DP_W'(10);
         3'd2:    return DP_W'(15);
         3'd3:    return DP_W'(25);
         3'd4:    return DP_W'(25);
         3'd5:    return DP_W'(25);
         default: return DP_W'(0);
      endcase
   endfunction

   function automatic logic [DV_W-1:0] seg_dv(input seg_type i);
      case (i)
         3'd1:    return DV_W'(800);
         3'd2:    return DV_W'(400);
         3'd3:    return DV_W'(400);
         3'd4:    return DV_W'(600);
         3'd5:    return DV_W'(1000);
         default: return DV_W'(0);
      endcase
   endfunction

   function automatic pct_type seg_base_pct(input seg_type i);
      case (i)
         3'd1:    return PCT_W'(0);
         3'd2:    return PCT_W'(10);
         3'd3:    return PCT_W'(25);
         3'd4:    return PCT_W'(50);
         3'd5:    return PCT_W'(75);
         default: return PCT_W'(0);
      endcase
   endfunction

   // reciprocal of twice the segment span, scaled by 2^RECIP_SHIFT, rounded up
   function automatic logic [RECIP_W-1:0] seg_recip(input seg_type i);
      case (i)
         3'd1:    return RECIP_W'(RECIP_1600);
         3'd2:    return RECIP_W'(RECIP_800);
         3'd3:    return RECIP_W'(RECIP_800);
         3'd4:    return RECIP_W'(RECIP_1200);
         3'd5:    return RECIP_W'(RECIP_2000);
         default: return RECIP_W'(0);
      endcase
   endfunction

endpackage

[design/bvg_if.sv]
// ----------------------------------------------------------------------------
// Battery voltage gauge channel interfaces
// Sample, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bvg_req_if import bvg_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_mv;

   modport source (output valid, output sample_mv, input ready);
   modport sink   (input valid, input sample_mv, output ready);
endinterface

interface bvg_rsp_if import bvg_pkg::*; ();
   logic    valid;
   logic    ready;
   mv_type  battery_mv;
   logic    reading_valid;
   pct_type charge_percent;

   modport source (output valid, output battery_mv, output reading_valid,
                   output charge_percent, input ready);
   modport sink   (input valid, input battery_mv, input reading_valid,
                   input charge_percent, output ready);
endinterface

interface bvg_csr_if import bvg_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/bvg_csr.sv]
// ----------------------------------------------------------------------------
// Battery voltage gauge configuration registers
// Divider ratio and plausible window, written over the register channel.
// ----------------------------------------------------------------------------
module bvg_csr import bvg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bvg_csr_if.sink   csr_chan,
   output cfg_type   cfg
);

   cfg_type cfg_ff;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divider_ratio     <= RATIO_W'(4);
         cfg_ff.plausible_low_mv  <= MV_LIMIT_W'(2500);
         cfg_ff.plausible_high_mv <= MV_LIMIT_W'(4500);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_DIVIDER_RATIO: begin
               cfg_ff.divider_ratio <= csr_chan.data[RATIO_W-1:0];
            end
            REG_PLAUSIBLE_LOW: begin
               cfg_ff.plausible_low_mv <= csr_chan.data;
            end
            REG_PLAUSIBLE_HIGH: begin
               cfg_ff.plausible_high_mv <= csr_chan.data;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

[design/battery_voltage_gauge_core.sv]
// ----------------------------------------------------------------------------
// Battery voltage gauge core
// Sums groups of samples, scales to quarter-millivolts, filters plausible
// readings and reports voltage, validity and interpolated charge percent.
// Throughput: one sample item per cycle, but a group's last waits while scale stalls.
// One result item per group; it passes through each stage register below in order.
// Stages: scale, divide and window test, filter, curve segment, percent.
// Reset: registers return to defaults; accumulator and filter are cleared.
// ----------------------------------------------------------------------------
module battery_voltage_gauge_core import bvg_pkg::*; #(
   parameter int unsigned SAMPLES_PER_READING = 16
) (
   input  logic      clock,
   input  logic      reset,
   bvg_req_if.sink   req_chan,
   bvg_rsp_if.source rsp_chan,
   bvg_csr_if.sink   csr_chan
);

   localparam int LOG_N    = $clog2(SAMPLES_PER_READING);
   localparam int SUM_W    = SAMPLE_W + LOG_N;
   localparam int SCALED_W = SUM_W + RATIO_W;
   localparam int X_W      = SCALED_W + 2;
   localparam int K        = X_W + LOG_N;
   localparam int MUL_W    = X_W + 1;
   localparam int PROD_W   = X_W + MUL_W;

   localparam logic [LOG_N-1:0] CNT_LAST = LOG_N'(SAMPLES_PER_READING - 1);
   localparam logic [MUL_W-1:0] RECIP    =
      MUL_W'(((64'd1 << K) + 64'(SAMPLES_PER_READING) - 64'd1) /
             64'(SAMPLES_PER_READING));

   cfg_type cfg;

   bvg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // accumulator
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [LOG_N-1:0]    count_ff;
   logic                group_done, req_accept;

   // stage registers
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic                s1_ready, s2_ready, s3_ready, s4_ready, out_ready;
   logic [SCALED_W-1:0] scaled_ff, scaled_in;
   qmv_type             q_ff, q_in;
   logic                plaus_ff, plaus_in;
   qmv_type             filt_ff, filt_in;
   logic                last_valid_ff;
   seg_type             seg_ff, seg_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   mv_type              mv_ff;
   logic                ok_ff;
   mv_type              battery_mv_ff;
   logic                reading_valid_ff;
   pct_type             charge_ff, charge_in;

   // datapath temporaries
   logic [X_W-1:0]      x_q;
   logic [PROD_W-1:0]   prod_q;
   logic [X_W-1:0]      q_wide;
   logic [SCALED_W-1:0] low_lim, high_lim;
   logic [QMV_W+1:0]    blend;
   logic [DIFF_W-1:0]   diff;
   logic [SDIFF_W-1:0]  sdiff;
   logic [QUO_W-1:0]    quo_full;
   logic [DP_W-1:0]     quo;

   assign out_ready = !out_valid_ff || rsp_chan.ready;
   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;

   assign group_done     = count_ff == CNT_LAST;
   assign req_chan.ready = !group_done || s1_ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // accumulate and scale
   assign sum_in    = sum_ff + SUM_W'(req_chan.sample_mv);
   assign scaled_in = SCALED_W'(sum_in) * SCALED_W'(cfg.divider_ratio);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (req_accept) begin
         if (group_done) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_ff + LOG_N'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_accept && group_done;
      end
      if (req_accept && group_done) begin
         scaled_ff <= scaled_in;
      end
   end

   // divide by group size and test window
   assign x_q      = {scaled_ff, 2'b00};
   assign prod_q   = PROD_W'(x_q) * PROD_W'(RECIP);
   assign q_wide   = X_W'(prod_q >> K);
   assign q_in     = (q_wide > X_W'(QMV_MAX)) ? QMV_MAX : QMV_W'(q_wide);
   assign low_lim  = SCALED_W'(cfg.plausible_low_mv) * SCALED_W'(SAMPLES_PER_READING);
   assign high_lim = SCALED_W'(cfg.plausible_high_mv) * SCALED_W'(SAMPLES_PER_READING);
   assign plaus_in = (scaled_ff >= low_lim) && (scaled_ff <= high_lim);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff && s2_ready) begin
         q_ff     <= q_in;
         plaus_ff <= plaus_in;
      end
   end

   // filter
   assign blend   = {2'b00, filt_ff} + {1'b0, filt_ff, 1'b0} + {2'b00, q_ff};
   assign filt_in = (plaus_ff && last_valid_ff) ? blend[QMV_W+1:2] : q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff   <= 1'b0;
         filt_ff       <= '0;
         last_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s2_valid_ff && s3_ready) begin
            filt_ff       <= filt_in;
            last_valid_ff <= plaus_ff;
         end
      end
   end

   // curve segment and interpolation numerator
   always_comb begin
      seg_in = SEG_FULL;
      for (int i = 5; i >= 0; i--) begin
         if (filt_ff <= bp_qmv(SEG_W'(i))) begin
            seg_in = SEG_W'(i);
         end
      end
   end

   assign diff   = DIFF_W'(filt_ff - bp_qmv(seg_in - SEG_W'(1)));
   assign sdiff  = SDIFF_W'(diff) * SDIFF_W'(seg_dp(seg_in));
   assign num_in = {sdiff, 1'b0} + NUM_W'(seg_dv(seg_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (s3_valid_ff && s4_ready) begin
         seg_ff <= seg_in;
         num_ff <= num_in;
         mv_ff  <= filt_ff[QMV_W-1:2];
         ok_ff  <= last_valid_ff;
      end
   end

   // percent
   assign quo_full = QUO_W'(num_ff) * QUO_W'(seg_recip(seg_ff));
   assign quo      = quo_full[RECIP_SHIFT +: DP_W];

   always_comb begin
      case (seg_ff)
         SEG_EMPTY: charge_in = PCT_ZERO;
         SEG_FULL:  charge_in = PCT_FULL;
         default:   charge_in = seg_base_pct(seg_ff) + PCT_W'(quo);
      endcase
      if (!ok_ff) begin
         charge_in = PCT_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s4_valid_ff;
      end
      if (s4_valid_ff && out_ready) begin
         battery_mv_ff    <= mv_ff;
         reading_valid_ff <= ok_ff;
         charge_ff        <= charge_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.battery_mv     = battery_mv_ff;
   assign rsp_chan.reading_valid  = reading_valid_ff;
   assign rsp_chan.charge_percent = charge_ff;

   a_group_enters : assert property (@(posedge clock) disable iff (reset)
      req_accept && group_done |=> s1_valid_ff)
      else $error("completed group did not enter the scale stage");

   a_filter_holds : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !s4_ready |=> $stable(filt_ff) && $stable(last_valid_ff))
      else $error("filter changed while its item was stalled");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.reading_valid |-> rsp_chan.charge_percent == PCT_ZERO)
      else $error("invalid reading reported a non-zero percent");

   a_pct_range : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.charge_percent <= PCT_FULL)
      else $error("charge percent above full scale");

endmodule

[tb/sv/tb_battery_voltage_gauge_core.sv]
// ----------------------------------------------------------------------------
// Battery voltage gauge core testbench
// Feeds millivolt samples in whole groups under several divider and window
// settings, predicts each group's voltage, validity and charge percent, and
// compares every result item in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_battery_voltage_gauge_core;
   timeunit 1ns;
   timeprecision 1ps;

   import bvg_pkg::*;

   localparam int GROUP          = 16;
   localparam int SETTLE         = 12;
   localparam int CYCLE_LIMIT    = 250000;
   localparam int LONG_HOLD      = 600;
   localparam int RANDOM_SAMPLES = 900;

   localparam int unsigned KNEE_QMV [6] = '{13600, 14400, 14800, 15200, 15800, 16800};
   localparam int unsigned KNEE_PCT [6] = '{0, 10, 25, 50, 75, 100};

   typedef struct {
      mv_type  battery_mv;
      logic    reading_valid;
      pct_type charge_percent;
   } reading_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   bvg_req_if req_bus ();
   bvg_rsp_if rsp_bus ();
   bvg_csr_if csr_bus ();

   battery_voltage_gauge_core #(.SAMPLES_PER_READING(GROUP)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   logic [RATIO_W-1:0]    ratio_cfg = 4'd4;
   logic [MV_LIMIT_W-1:0] low_cfg   = 14'd2500;
   logic [MV_LIMIT_W-1:0] high_cfg  = 14'd4500;
   int unsigned group_sum   = 0;
   int unsigned group_count = 0;
   int unsigned filt_qmv    = 0;
   bit          last_in_window = 1'b0;

   sample_type  sample_queue[$];
   reading_type expected_readings[$];
   int error_count = 0;

   int burst_left = 0;
   int gap_left   = 0;

   stall_type stall_mode = STALL_NONE;
   int mode_left     = 0;
   int hold_left     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int cycle_count   = 0;

   function automatic int unsigned percent_of(input int unsigned v);
      int unsigned num;
      int i;
      if (v <= KNEE_QMV[0]) return 0;
      for (i = 1; i < 6; i++) begin
         if (v <= KNEE_QMV[i]) begin
            num = 2 * (v - KNEE_QMV[i-1]) * (KNEE_PCT[i] - KNEE_PCT[i-1])
                  + (KNEE_QMV[i] - KNEE_QMV[i-1]);
            return KNEE_PCT[i-1] + num / (2 * (KNEE_QMV[i] - KNEE_QMV[i-1]));
         end
      end
      return 100;
   endfunction

   function void take_sample(input sample_type s);
      int unsigned scaled;
      int unsigned qmv;
      bit          in_window;
      reading_type r;
      group_sum   += s;
      group_count += 1;
      if (group_count < GROUP) return;
      scaled = group_sum * ratio_cfg;
      qmv    = scaled * 4 / GROUP;
      if (qmv > QMV_MAX) qmv = QMV_MAX;
      in_window = scaled >= low_cfg * GROUP && scaled <= high_cfg * GROUP;
      if (in_window && last_in_window)
         filt_qmv = (3 * filt_qmv + qmv) >> 2;
      else
         filt_qmv = qmv;
      filt_qmv       = filt_qmv & QMV_MAX;
      last_in_window = in_window;
      group_sum      = 0;
      group_count    = 0;
      r.battery_mv     = mv_type'(filt_qmv >> 2);
      r.reading_valid  = in_window;
      r.charge_percent = in_window ? pct_type'(percent_of(filt_qmv)) : PCT_ZERO;
      expected_readings.push_back(r);
   endfunction

   function void push_group_sum(input int unsigned total, input int jitter);
      int unsigned base;
      int unsigned extra;
      int v;
      int i;
      base  = total / GROUP;
      extra = total % GROUP;
      for (i = 0; i < GROUP; i++) begin
         v = base + ((i < extra) ? 1 : 0);
         if (jitter > 0) v += int'($urandom_range(0, 2 * jitter)) - jitter;
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         sample_queue.push_back(sample_type'(v));
      end
   endfunction

   function void push_noise_group();
      int i;
      for (i = 0; i < GROUP; i++)
         sample_queue.push_back(sample_type'($urandom_range(0, 4095)));
   endfunction

   function void push_reading_near(input int ratio, input int unsigned mv, input int jitter);
      if (ratio == 0)
         push_noise_group();
      else
         push_group_sum(mv * GROUP / ratio, jitter);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_bus.valid || expected_readings.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input csr_data_type value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock);
      while (!csr_bus.ready);
      case (idx)
         REG_DIVIDER_RATIO:  ratio_cfg = value[RATIO_W-1:0];
         REG_PLAUSIBLE_LOW:  low_cfg   = value;
         REG_PLAUSIBLE_HIGH: high_cfg  = value;
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(input int ratio_word, input int low, input int high);
      wait_drained();
      write_register(REG_DIVIDER_RATIO, csr_data_type'(ratio_word));
      write_register(REG_PLAUSIBLE_LOW, csr_data_type'(low));
      write_register(REG_PLAUSIBLE_HIGH, csr_data_type'(high));
   endtask

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.sample_mv <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            take_sample(req_bus.sample_mv);
            void'(sample_queue.pop_front());
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left      <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               req_bus.valid     <= 1'b1;
               req_bus.sample_mv <= sample_queue[0];
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 48);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check results and stall on a pattern of its own
   always @(posedge clock) begin : result_check
      reading_type want;
      logic        open;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("unexpected item, battery_mv %0d",
                                         rsp_bus.battery_mv));
            end else begin
               want = expected_readings.pop_front();
               if (rsp_bus.battery_mv !== want.battery_mv)
                  report_mismatch($sformatf("battery_mv %0d, expected %0d",
                                            rsp_bus.battery_mv, want.battery_mv));
               if (rsp_bus.reading_valid !== want.reading_valid)
                  report_mismatch($sformatf("reading_valid %0b, expected %0b",
                                            rsp_bus.reading_valid, want.reading_valid));
               if (rsp_bus.charge_percent !== want.charge_percent)
                  report_mismatch($sformatf("charge_percent %0d, expected %0d",
                                            rsp_bus.charge_percent, want.charge_percent));
            end
         end
         if (mode_left == 0) begin
            stall_mode <= stall_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  open = 1'b1;
            STALL_LIGHT: open = ($urandom_range(0, 3) != 0);
            STALL_HALF:  open = ($urandom_range(0, 1) != 0);
            default:     open = ($urandom_range(0, 4) == 0);
         endcase
         rsp_bus.ready <= open && (hold_left == 0);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_left   <= LONG_HOLD;
         hold_served <= hold_requests;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_battery_voltage_gauge_core: errors");
         $finish;
      end
   end

   initial begin
      int phase_no;
      int groups;
      int g;
      int kind;
      int ratio;
      int low;
      int high;
      int random_samples;

      csr_bus.valid     = 1'b0;
      csr_bus.index     = REG_DIVIDER_RATIO;
      csr_bus.data      = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: breakpoints, window edges, blending run, full scale
      push_group_sum(0, 0);     push_group_sum(13600, 0);
      push_group_sum(0, 0);     push_group_sum(13601, 0);
      push_group_sum(0, 0);     push_group_sum(14400, 0);
      push_group_sum(0, 0);     push_group_sum(15000, 0);
      push_group_sum(0, 0);     push_group_sum(16800, 0);
      push_group_sum(0, 0);     push_group_sum(16801, 0);
      push_group_sum(9999, 0);  push_group_sum(10000, 0);
      push_group_sum(18000, 0); push_group_sum(18001, 0);
      push_group_sum(15000, 0); push_group_sum(16000, 0);
      push_group_sum(15500, 0); push_group_sum(14000, 0);
      push_group_sum(65520, 0);

      // ratio above eight with the unused data bits set; saturation
      configure(16383, 0, 16383);
      push_group_sum(65520, 0); push_group_sum(0, 0);
      push_group_sum(17000, 0); push_group_sum(17475, 0);
      push_group_sum(17476, 0);

      // ratio zero, accepted and refused
      configure(0, 0, 0);
      push_noise_group();
      push_group_sum(65520, 0);
      configure(0, 1, 16383);
      push_group_sum(65520, 0);
      push_group_sum(0, 0);

      // inverted window
      configure(8, 4500, 2500);
      push_group_sum(7600, 0);
      push_group_sum(0, 0);

      // ratio one
      configure(1, 3000, 4095);
      push_group_sum(65520, 0);
      push_group_sum(60000, 0);
      push_group_sum(58000, 0);

      random_samples = 0;
      phase_no       = 0;
      while (random_samples < RANDOM_SAMPLES) begin
         kind = $urandom_range(0, 9);
         if (kind < 8)
            ratio = kind + 1;
         else if (kind == 8)
            ratio = 0;
         else
            ratio = $urandom_range(9, 15);
         if ($urandom_range(0, 4) != 0) begin
            low  = $urandom_range(2500, 3400);
            high = $urandom_range(4100, 4600);
         end else begin
            low  = $urandom_range(0, 16383);
            high = $urandom_range(0, 16383);
         end
         configure(ratio, low, high);
         groups = $urandom_range(3, 8);
         if (phase_no % 5 == 2) begin
            @(negedge clock);
            hold_requests++;
            groups = 12;
         end
         for (g = 0; g < groups; g++) begin
            kind = $urandom_range(0, 19);
            if (kind < 12)
               push_reading_near(ratio, $urandom_range(3300, 4300), $urandom_range(0, 80));
            else if (kind < 15)
               push_reading_near(ratio, $urandom_range(2300, 4800), $urandom_range(0, 200));
            else if (kind < 17)
               push_noise_group();
            else if (kind < 19)
               push_group_sum($urandom_range(48000, 65520), 200);
            else
               push_group_sum($urandom_range(0, 2000), 100);
         end
         random_samples += groups * GROUP;
         phase_no++;
      end

      wait_drained();
      if (error_count == 0)
         $display("tb_battery_voltage_gauge_core: clean");
      else
         $display("tb_battery_voltage_gauge_core: errors");
      $finish;
   end

endmodule
